FILE: rtl/edr_pkg.sv
// Shared types and constants of the extended real divider.
// No dependencies; the other rtl files but edr_checker refer to it by scoped names.
`timescale 1ns / 1ps
package edr_pkg;

  localparam int MantBits = 64;
  localparam int ExpBits  = 17;
  localparam int CntBits  = 6;
  localparam logic [ExpBits-1:0] ExpBias = 17'd16383;
  localparam logic [ExpBits-1:0] ExpMax  = 17'h07fff;

  typedef enum logic [1:0] {
    JOB_DIVZ,
    JOB_UNDER,
    JOB_NORMAL
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic                  sign;
    logic [ExpBits-1:0]    exp;
    logic [MantBits-1:0]   dividend;
    logic [MantBits-1:0]   divisor;
  } job_t;

  typedef struct packed {
    logic                  written;
    logic [15:0]           sign_exp;
    logic [MantBits-1:0]   mantissa;
    logic                  zero_divide;
    logic                  underflow;
    logic                  denormal;
    logic                  overflow;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM_D,
    BK_DIV,
    BK_NORM_Q,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/extended_real_divider.sv
// Top level of the 80-bit extended real divider (truncating quotient).
// Depends on edr_pkg, edr_front, edr_queue and edr_back.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | two sign/exponent words, two mantissas
//   out_    | output    | out_valid/out_ready | written bit, sign/exponent, mantissa, flags
//
// Steps: a normal item is dequeued, its divisor is shifted left past its leading
// zeros, the restoring divide yields one quotient bit per cycle and the quotient
// is normalized; then its result is held until its transfer. Zero-divide and
// underflow items finish in the dequeue cycle. The shared divide loop sets the
// rate.
// Reset (rst_n low, synchronous) empties the queue and idles the back end.
// A stalled output stalls only the back end; the front keeps taking items
// until the two-entry queue fills.
`timescale 1ns / 1ps
module extended_real_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_dividend_sign_exp,
  input  logic [63:0] in_dividend_mantissa,
  input  logic [15:0] in_divisor_sign_exp,
  input  logic [63:0] in_divisor_mantissa,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_written,
  output logic [15:0] out_result_sign_exp,
  output logic [63:0] out_result_mantissa,
  output logic        out_zero_divide_flag,
  output logic        out_underflow_flag,
  output logic        out_denormal_flag,
  output logic        out_overflow_flag
);

  edr_pkg::job_t    front_job;
  edr_pkg::job_t    head_job;
  edr_pkg::result_t res;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;

  // Classify the incoming pair as it arrives.
  edr_front u_front (
    .dividend_sign_exp (in_dividend_sign_exp),
    .dividend_mantissa (in_dividend_mantissa),
    .divisor_sign_exp  (in_divisor_sign_exp),
    .divisor_mantissa  (in_divisor_mantissa),
    .job               (front_job)
  );

  // Hold accepted jobs until the back end is free.
  assign in_ready = !q_full;

  edr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Carry out the divide and hold the result for transfer.
  edr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_result_written   = res.written;
  assign out_result_sign_exp  = res.sign_exp;
  assign out_result_mantissa  = res.mantissa;
  assign out_zero_divide_flag = res.zero_divide;
  assign out_underflow_flag   = res.underflow;
  assign out_denormal_flag    = res.denormal;
  assign out_overflow_flag    = res.overflow;

endmodule

FILE: rtl/edr_front.sv
// Front end: classifies an incoming operand pair into a job record.
// Depends on edr_pkg.
`timescale 1ns / 1ps
module edr_front (
  input  logic [15:0]           dividend_sign_exp,
  input  logic [63:0]           dividend_mantissa,
  input  logic [15:0]           divisor_sign_exp,
  input  logic [63:0]           divisor_mantissa,
  output edr_pkg::job_t         job
);

  logic [edr_pkg::ExpBits-1:0] raw_exp;

  // Bit 16 set means the raw biased exponent went negative.
  assign raw_exp = {2'b00, dividend_sign_exp[14:0]} - {2'b00, divisor_sign_exp[14:0]}
                   + edr_pkg::ExpBias;

  always_comb begin
    job.sign     = dividend_sign_exp[15] ^ divisor_sign_exp[15];
    job.exp      = raw_exp;
    job.dividend = dividend_mantissa;
    job.divisor  = divisor_mantissa;
    if (divisor_mantissa == 64'd0) begin
      job.kind = edr_pkg::JOB_DIVZ;
    end else if (raw_exp[edr_pkg::ExpBits-1]) begin
      job.kind = edr_pkg::JOB_UNDER;
    end else begin
      job.kind = edr_pkg::JOB_NORMAL;
    end
  end

endmodule

FILE: rtl/edr_queue.sv
// Two-entry job queue between front and back end.
// Depends on edr_pkg.
`timescale 1ns / 1ps
module edr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  edr_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output edr_pkg::job_t  head_job
);

  edr_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/edr_back.sv
// Back end: divisor normalize, 64-step restoring divide, quotient normalize.
// Depends on edr_pkg.
`timescale 1ns / 1ps
module edr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  edr_pkg::job_t    job,
  output logic             job_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output edr_pkg::result_t res
);

  edr_pkg::back_state_t          state_r, state_nxt;
  logic                          sign_r, sign_nxt;
  logic [edr_pkg::ExpBits-1:0]   exp_r, exp_nxt;
  logic [63:0]                   div_r, div_nxt;
  logic [64:0]                   rem_r, rem_nxt;
  logic [63:0]                   quo_r, quo_nxt;
  logic [edr_pkg::CntBits-1:0]   cnt_r, cnt_nxt;
  edr_pkg::result_t              res_r, res_nxt;
  logic                          ge;
  logic [64:0]                   rem_sub;

  assign res_valid = (state_r == edr_pkg::BK_DONE);
  assign res       = res_r;
  assign ge        = (rem_r >= {1'b0, div_r});
  assign rem_sub   = ge ? (rem_r - {1'b0, div_r}) : rem_r;

  always_comb begin
    state_nxt = state_r;
    sign_nxt  = sign_r;
    exp_nxt   = exp_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    job_pop   = 1'b0;
    unique case (state_r)
      edr_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop  = 1'b1;
          sign_nxt = job.sign;
          exp_nxt  = job.exp;
          div_nxt  = job.divisor;
          rem_nxt  = {1'b0, job.dividend};
          res_nxt  = '0;
          unique case (job.kind)
            edr_pkg::JOB_DIVZ: begin
              res_nxt.zero_divide = 1'b1;
              state_nxt = edr_pkg::BK_DONE;
            end
            edr_pkg::JOB_UNDER: begin
              res_nxt.written   = 1'b1;
              res_nxt.sign_exp  = {job.sign, 15'd0};
              res_nxt.underflow = 1'b1;
              state_nxt = edr_pkg::BK_DONE;
            end
            default: state_nxt = edr_pkg::BK_NORM_D;
          endcase
        end
      end
      edr_pkg::BK_NORM_D: begin
        // Shift one place per cycle until the integer bit is set.
        if (div_r[63]) begin
          cnt_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = edr_pkg::BK_DIV;
        end else begin
          div_nxt = {div_r[62:0], 1'b0};
          exp_nxt = exp_r + 1'b1;
        end
      end
      edr_pkg::BK_DIV: begin
        // Remainder stays below the divisor after the subtract, so it fits 64 bits.
        quo_nxt = {quo_r[62:0], ge};
        rem_nxt = {rem_sub[63:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {edr_pkg::CntBits{1'b1}}) begin
          state_nxt = edr_pkg::BK_NORM_Q;
        end
      end
      edr_pkg::BK_NORM_Q: begin
        if (quo_r != 64'd0 && exp_r != '0 && !quo_r[63]) begin
          exp_nxt = exp_r - 1'b1;
          quo_nxt = {quo_r[62:0], 1'b0};
        end else begin
          res_nxt = '0;
          if (quo_r == 64'd0) begin
            res_nxt.written  = 1'b1;
            res_nxt.sign_exp = {sign_r, 15'd0};
          end else if (exp_r > edr_pkg::ExpMax) begin
            res_nxt.overflow = 1'b1;
            res_nxt.denormal = !quo_r[63];
          end else begin
            res_nxt.written  = 1'b1;
            res_nxt.sign_exp = {sign_r, exp_r[14:0]};
            res_nxt.mantissa = quo_r;
            res_nxt.denormal = !quo_r[63];
          end
          state_nxt = edr_pkg::BK_DONE;
        end
      end
      edr_pkg::BK_DONE: begin
        if (res_ready) begin
          state_nxt = edr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = edr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edr_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
    exp_r  <= exp_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: rtl/edr_checker.sv
// Port-level checks for extended_real_divider, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module edr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_written,
  input logic [63:0] out_result_mantissa,
  input logic        out_zero_divide_flag,
  input logic        out_underflow_flag,
  input logic        out_denormal_flag,
  input logic        out_overflow_flag
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_mantissa))
    else $error("result dropped or changed while stalled");

  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_zero_divide_flag || out_overflow_flag) |-> !out_result_written)
    else $error("result written on zero-divide or overflow");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_underflow_flag |-> out_result_mantissa == 64'd0 && out_result_written)
    else $error("underflow result not a signed zero");

  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_written && !out_denormal_flag && out_result_mantissa != 64'd0
    |-> out_result_mantissa[63])
    else $error("written quotient not normalized");

endmodule

bind extended_real_divider edr_checker u_edr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_result_written   (out_result_written),
  .out_result_mantissa  (out_result_mantissa),
  .out_zero_divide_flag (out_zero_divide_flag),
  .out_underflow_flag   (out_underflow_flag),
  .out_denormal_flag    (out_denormal_flag),
  .out_overflow_flag    (out_overflow_flag)
);

FILE: tb/tb.sv
// Self-checking bench for extended_real_divider: random and directed divides.
// Depends on edr_pkg and the rtl of extended_real_divider; predicts each quotient itself.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [15:0] se1;
    logic [63:0] m1;
    logic [15:0] se2;
    logic [63:0] m2;
  } operands_t;

  typedef struct {
    logic        written;
    logic [15:0] sign_exp;
    logic [63:0] mantissa;
    logic        zdiv;
    logic        under;
    logic        denorm;
    logic        over;
  } quotient_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_dividend_sign_exp;
  logic [63:0] in_dividend_mantissa;
  logic [15:0] in_divisor_sign_exp;
  logic [63:0] in_divisor_mantissa;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_written;
  logic [15:0] out_result_sign_exp;
  logic [63:0] out_result_mantissa;
  logic        out_zero_divide_flag;
  logic        out_underflow_flag;
  logic        out_denormal_flag;
  logic        out_overflow_flag;

  operands_t pending_ops[$];
  quotient_t expected_quotients[$];
  int        mismatches;
  int        cycles;
  int        burst_left;
  int        gap_left;
  bit        hold_for_drain;
  bit        hold_request;
  int        stall_phase;

  extended_real_divider uut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predict one quotient: sign xor, biased exponent difference, restoring divide.
  function automatic quotient_t predict_quotient(operands_t op);
    quotient_t   r;
    logic        sgn;
    int          e;
    logic [63:0] d;
    logic [127:0] rem;
    logic [127:0] dv;
    logic [63:0] q;
    sgn = op.se1[15] ^ op.se2[15];
    r = '{default: '0};
    d = op.m2;
    if (d == 64'd0) begin
      r.zdiv = 1'b1;
      return r;
    end
    e = int'(op.se1[14:0]) - int'(op.se2[14:0]) + 16383;
    if (e < 0) begin
      r.written = 1'b1;
      r.sign_exp = {sgn, 15'd0};
      r.under = 1'b1;
      return r;
    end
    while (!d[63]) begin
      d = d << 1;
      e++;
    end
    rem = {op.m1, 64'd0};
    dv = {d, 64'd0};
    q = '0;
    for (int k = 0; k < 64; k++) begin
      if (rem >= dv) begin
        rem = rem - dv;
        q[63-k] = 1'b1;
      end
      dv = dv >> 1;
    end
    if (q != 0) begin
      while (e != 0 && !q[63]) begin
        e--;
        q = q << 1;
      end
      r.denorm = !q[63];
    end else begin
      e = 0;
    end
    if (e > 32767) begin
      r.over = 1'b1;
      r.denorm = 1'b0;
      return r;
    end
    r.written = 1'b1;
    r.sign_exp = {sgn, e[14:0]};
    r.mantissa = q;
    return r;
  endfunction

  function automatic logic [63:0] rand_mant();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: m = m >> $urandom_range(1, 63);
      1: m[63] = 1'b1;
      2: m = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return m;
  endfunction

  task automatic add_divide(logic [15:0] se1, logic [63:0] m1, logic [15:0] se2,
                            logic [63:0] m2);
    operands_t op;
    op.se1 = se1;
    op.m1 = m1;
    op.se2 = se2;
    op.m2 = m2;
    pending_ops.push_back(op);
  endtask

  // Driver: send in bursts; hold off once until every quotient has come back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_dividend_sign_exp <= '0;
      in_dividend_mantissa <= '0;
      in_divisor_sign_exp <= '0;
      in_divisor_mantissa <= '0;
      burst_left <= 0;
      gap_left <= 0;
      hold_for_drain <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid && in_ready) begin
        expected_quotients.push_back(predict_quotient(pending_ops.pop_front()));
      end
      if (hold_request && !hold_for_drain) begin
        hold_for_drain <= 1'b1;
        in_valid <= 1'b0;
      end else if (hold_for_drain && hold_request) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_valid <= 1'b1;
        in_dividend_sign_exp <= pending_ops[0].se1;
        in_dividend_mantissa <= pending_ops[0].m1;
        in_divisor_sign_exp <= pending_ops[0].se2;
        in_divisor_mantissa <= pending_ops[0].m2;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall pattern on out_ready, compare each transfer to the oldest prediction.
  always @(posedge clk) begin
    quotient_t exp_q;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[8:6] == 3'd0) ? 1'b1 :
                   (stall_phase[8:6] == 3'd5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) begin
        if (expected_quotients.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
        end else begin
          exp_q = expected_quotients.pop_front();
          if (out_result_written !== exp_q.written || out_result_sign_exp !== exp_q.sign_exp ||
              out_result_mantissa !== exp_q.mantissa ||
              out_zero_divide_flag !== exp_q.zdiv || out_underflow_flag !== exp_q.under ||
              out_denormal_flag !== exp_q.denorm || out_overflow_flag !== exp_q.over) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp w%b se%h m%h z%b u%b d%b o%b got w%b se%h m%h z%b u%b d%b o%b",
                       exp_q.written, exp_q.sign_exp, exp_q.mantissa, exp_q.zdiv, exp_q.under,
                       exp_q.denorm, exp_q.over, out_result_written, out_result_sign_exp,
                       out_result_mantissa, out_zero_divide_flag, out_underflow_flag,
                       out_denormal_flag, out_overflow_flag);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] e1;
    logic [15:0] e2;
    hold_request = 1'b0;
    rst_n = 1'b0;

    // Directed: zero divisor, underflow, zero quotient, denormal, overflow, extremes.
    add_divide(16'h3fff, 64'h8000_0000_0000_0000, 16'h3fff, 64'd0);
    add_divide(16'hffff, '1, 16'hffff, 64'd0);
    add_divide(16'h0000, '1, 16'h7fff, '1);
    add_divide(16'h8001, 64'h8000_0000_0000_0000, 16'h4000, 64'hc000_0000_0000_0000);
    add_divide(16'h3fff, 64'd0, 16'hbfff, 64'h8000_0000_0000_0000);
    add_divide(16'h0000, 64'd1, 16'h3fff, 64'h8000_0000_0000_0000);
    add_divide(16'h0010, 64'h0000_0000_0000_0003, 16'h3fff, '1);
    add_divide(16'h7fff, '1, 16'h0000, 64'd1);
    add_divide(16'h7fff, '1, 16'h3fff, 64'h8000_0000_0000_0000);
    add_divide(16'hc000, '1, 16'h3fff, 64'd1);
    add_divide(16'h3fff, 64'h8000_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000);
    add_divide(16'h3fff, '1, 16'h3fff, '1);
    add_divide(16'h4000, 64'h1234_5678_9abc_def0, 16'h3ffe, 64'h0fed_cba9_8765_4321);
    add_divide(16'h0000, 64'd0, 16'h0000, 64'd1);
    add_divide(16'h7fff, 64'hffff_ffff_ffff_fffe, 16'hffff, '1);
    add_divide(16'h3fff, 64'd5, 16'h3fff, 64'd3);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 600; i++) begin
      if (i == 300) begin
        wait (pending_ops.size() == 0 && !in_valid);
        hold_request = 1'b1;
        wait (expected_quotients.size() == 0);
        @(posedge clk);
        hold_request = 1'b0;
      end
      e1 = $urandom;
      e2 = $urandom;
      case ($urandom_range(0, 3))
        0: e2[14:0] = e1[14:0] + 15'($urandom_range(0, 40)) - 15'd20;
        1: e2[14:0] = 15'h3fff + 15'($urandom_range(0, 200)) - 15'd100;
        default: ;
      endcase
      add_divide(e1, rand_mant(), e2, ($urandom_range(0, 30) == 0) ? 64'd0 : rand_mant());
    end

    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_quotients.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
